FILE: design/che_pkg.sv
// ----------------------------------------------------------------------------
// che_pkg
// Shared types and constants for the coinbase height extractor.
// ----------------------------------------------------------------------------
package che_pkg;

  localparam logic [7:0] FF_BYTE = 8'hff;

  // height length codes that widen the field past 16 bits
  localparam logic [7:0] HLEN_3 = 8'd3;
  localparam logic [7:0] HLEN_4 = 8'd4;

  localparam logic [2:0] NEED_2 = 3'd2;
  localparam logic [2:0] NEED_3 = 3'd3;
  localparam logic [2:0] NEED_4 = 3'd4;

  typedef enum logic [5:0] {
    PH_SEEK  = 6'b000001,
    PH_RUN   = 6'b000010,
    PH_HLEN  = 6'b000100,
    PH_FIELD = 6'b001000,
    PH_DONE  = 6'b010000,
    PH_FAIL  = 6'b100000
  } phase_t;

  // one registered input word
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } in_word_t;

  // one result word
  typedef struct packed {
    logic [31:0] height;
    logic        found;
  } result_t;

endpackage

FILE: design/coinbase_height_extractor_top.sv
// ----------------------------------------------------------------------------
// coinbase_height_extractor_top
// Block height extraction from a coinbase byte stream.
// ----------------------------------------------------------------------------
// Takes one coinbase byte per cycle, with no gaps required between coinbases.
// Each byte passes an input register and then a single parse-state update;
// the result of a coinbase is loaded into the output register as its last
// byte leaves the input register. A full output register blocks only a stream's
// last byte; other bytes keep flowing. height is 0 whenever found is 0.
module coinbase_height_extractor_top #(
  parameter int HEADER_SKIP = 32,
  parameter int SCAN_WINDOW = 128
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] height,
  output logic        found
);
  import che_pkg::*;

  in_word_t word;
  result_t  res;
  logic     word_valid;
  logic     can_load;
  logic     adv;

  // hold a last byte while the result register is still full
  assign adv = word_valid && (!word.last || can_load);

  che_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .data_byte  (data_byte),
    .last_byte  (last_byte),
    .adv        (adv),
    .word_valid (word_valid),
    .word       (word)
  );

  che_parser #(
    .HEADER_SKIP (HEADER_SKIP),
    .SCAN_WINDOW (SCAN_WINDOW)
  ) u_parser (
    .clk  (clk),
    .rst  (rst),
    .adv  (adv),
    .word (word),
    .res  (res)
  );

  che_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (adv && word.last),
    .res       (res),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .height    (height),
    .found     (found)
  );

  a_zero_height: assert property (@(posedge clk) disable iff (rst)
    out_valid && !found |-> height == 32'd0)
    else $error("nonzero height without found");

  a_last_load: assert property (@(posedge clk) disable iff (rst)
    adv && word.last |=> out_valid)
    else $error("result lost after last byte");

  a_no_drop: assert property (@(posedge clk) disable iff (rst)
    word_valid && word.last && !can_load |-> !adv)
    else $error("last byte advanced into a full result register");

endmodule

FILE: design/che_in_stage.sv
// ----------------------------------------------------------------------------
// che_in_stage
// Input register: holds one accepted byte until the parser consumes it.
// ----------------------------------------------------------------------------
module che_in_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        data_byte,
  input  logic              last_byte,
  input  logic              adv,
  output logic              word_valid,
  output che_pkg::in_word_t word
);
  import che_pkg::*;

  assign in_ready = !word_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid <= 1'b0;
    end else if (in_ready) begin
      word_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      word.data <= data_byte;
      word.last <= last_byte;
    end
  end

endmodule

FILE: design/che_parser.sv
// ----------------------------------------------------------------------------
// che_parser
// Running parse state: window tracking, ff-run search, height field capture.
// ----------------------------------------------------------------------------
module che_parser #(
  parameter int HEADER_SKIP = 32,
  parameter int SCAN_WINDOW = 128
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              adv,
  input  che_pkg::in_word_t word,
  output che_pkg::result_t  res
);
  import che_pkg::*;

  localparam int WIN_END = HEADER_SKIP + SCAN_WINDOW;
  localparam int OFS_W   = $clog2(WIN_END + 1);

  logic [OFS_W-1:0] byte_offset, byte_offset_next;
  phase_t           parse_phase, parse_phase_next;
  logic [1:0]       ff_run_length, ff_run_length_next;
  logic [7:0]       height_length, height_length_next;
  logic [31:0]      height_accum, height_accum_next;
  logic [2:0]       field_byte_index, field_byte_index_next;
  logic             in_win;
  logic [2:0]       need;

  assign in_win = (byte_offset >= OFS_W'(HEADER_SKIP)) && (byte_offset < OFS_W'(WIN_END));
  assign need   = (height_length == HLEN_4) ? NEED_4 :
                  (height_length == HLEN_3) ? NEED_3 : NEED_2;

  always_comb begin
    parse_phase_next      = parse_phase;
    ff_run_length_next    = ff_run_length;
    height_length_next    = height_length;
    height_accum_next     = height_accum;
    field_byte_index_next = field_byte_index;
    byte_offset_next      = byte_offset;
    if (byte_offset < OFS_W'(WIN_END)) begin
      byte_offset_next = byte_offset + 1'b1;
    end
    if (in_win) begin
      unique case (parse_phase)
        PH_SEEK: begin
          if (word.data == FF_BYTE) begin
            ff_run_length_next = 2'd1;
            parse_phase_next   = PH_RUN;
          end
        end
        PH_RUN: begin
          if (word.data == FF_BYTE) begin
            if (ff_run_length < 2'd2) ff_run_length_next = ff_run_length + 2'd1;
          end else begin
            // the byte ending the run is the skipped length byte
            parse_phase_next = (ff_run_length >= 2'd2) ? PH_HLEN : PH_FAIL;
          end
        end
        PH_HLEN: begin
          height_length_next    = word.data;
          field_byte_index_next = 3'd0;
          parse_phase_next      = PH_FIELD;
        end
        PH_FIELD: begin
          height_accum_next = height_accum |
                              (32'(word.data) << {field_byte_index[1:0], 3'b000});
          field_byte_index_next = field_byte_index + 3'd1;
          if (field_byte_index + 3'd1 >= need) parse_phase_next = PH_DONE;
        end
        PH_DONE, PH_FAIL: begin
        end
        default: begin
        end
      endcase
    end
  end

  assign res.found  = (parse_phase_next == PH_DONE);
  assign res.height = res.found ? height_accum_next : 32'd0;

  always_ff @(posedge clk) begin
    if (rst || (adv && word.last)) begin
      byte_offset      <= '0;
      parse_phase      <= PH_SEEK;
      ff_run_length    <= 2'd0;
      height_length    <= 8'd0;
      height_accum     <= 32'd0;
      field_byte_index <= 3'd0;
    end else if (adv) begin
      byte_offset      <= byte_offset_next;
      parse_phase      <= parse_phase_next;
      ff_run_length    <= ff_run_length_next;
      height_length    <= height_length_next;
      height_accum     <= height_accum_next;
      field_byte_index <= field_byte_index_next;
    end
  end

  a_restart: assert property (@(posedge clk) disable iff (rst)
    adv && word.last |=> parse_phase == PH_SEEK && byte_offset == '0)
    else $error("parse state not cleared after last byte");

  a_offset_sat: assert property (@(posedge clk) disable iff (rst)
    byte_offset <= OFS_W'(WIN_END))
    else $error("byte offset past window end");

  a_field_idx: assert property (@(posedge clk) disable iff (rst)
    parse_phase == PH_FIELD |-> field_byte_index < NEED_4)
    else $error("height field index overran");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(parse_phase) && $stable(height_accum))
    else $error("parse state moved without a byte");

endmodule

FILE: design/che_out_reg.sv
// ----------------------------------------------------------------------------
// che_out_reg
// Result register: holds one result word until the consumer takes it.
// ----------------------------------------------------------------------------
module che_out_reg (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  che_pkg::result_t res,
  output logic             can_load,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [31:0]      height,
  output logic             found
);
  import che_pkg::*;

  assign can_load = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (can_load) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && can_load) begin
      height <= res.height;
      found  <= res.found;
    end
  end

endmodule

FILE: tb/coinbase_height_extractor_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// coinbase_height_extractor_top_test
// Self-checking bench for the coinbase height extractor.
// ----------------------------------------------------------------------------
// Streams whole coinbases into the block one byte word at a time and predicts
// each height/found word from its own copy of the parse state. Directed
// coinbases cover short data, missing or single 0xff runs, runs and fields
// cut off by the window or the data, height length codes 0 to 5 and 0xff, and zero and
// all-ones heights. Random coinbases, mostly well formed with random content,
// follow under four idling patterns on the two handshakes.
module coinbase_height_extractor_top_test;
  import che_pkg::*;

  localparam int HDR_BYTES    = 32;
  localparam int WIN_BYTES    = 128;
  localparam int WIN_LIMIT    = HDR_BYTES + WIN_BYTES;
  localparam int OUT_LATENCY  = 2;
  localparam int STALL_LIMIT  = 1000;
  localparam int TOTAL_BYTES  = 1850;
  localparam int MAX_REPORTS  = 10;

  typedef enum logic [1:0] {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte = 8'd0;
  logic        last_byte = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] height;
  logic        found;

  coinbase_height_extractor_top #(
    .HEADER_SKIP(HDR_BYTES),
    .SCAN_WINDOW(WIN_BYTES)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .data_byte(data_byte),
    .last_byte(last_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .height   (height),
    .found    (found)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // predicted parse state
  int unsigned scan_pos;
  phase_t      scan_phase;
  logic [1:0]  ff_count;
  logic [7:0]  hgt_len;
  logic [31:0] hgt_acc;
  logic [2:0]  hgt_idx;

  result_t    due_results[$];
  logic [7:0] cb_bytes[$];
  result_t    head_result;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int errors         = 0;
  int coinbases_sent = 0;
  int bytes_sent     = 0;
  int window_bytes   = 0;
  int results_seen   = 0;
  int found_seen     = 0;
  int idle_cycles    = 0;
  int phase_bytes    = 0;

  task automatic clear_parse();
    scan_pos   = 0;
    scan_phase = PH_SEEK;
    ff_count   = 2'd0;
    hgt_len    = 8'd0;
    hgt_acc    = 32'd0;
    hgt_idx    = 3'd0;
  endtask

  task automatic predict_byte(input logic [7:0] b, input logic l);
    logic [2:0] need;
    result_t    res;
    if (scan_pos >= HDR_BYTES && scan_pos < WIN_LIMIT) begin
      window_bytes++;
      case (scan_phase)
        PH_SEEK: begin
          if (b == FF_BYTE) begin
            ff_count   = 2'd1;
            scan_phase = PH_RUN;
          end
        end
        PH_RUN: begin
          if (b == FF_BYTE) begin
            if (ff_count < 2'd2) ff_count = ff_count + 2'd1;
          end else begin
            // the byte ending the run is the skipped length byte
            scan_phase = (ff_count >= 2'd2) ? PH_HLEN : PH_FAIL;
          end
        end
        PH_HLEN: begin
          hgt_len    = b;
          hgt_idx    = 3'd0;
          scan_phase = PH_FIELD;
        end
        PH_FIELD: begin
          need = (hgt_len == HLEN_4) ? NEED_4 : (hgt_len == HLEN_3) ? NEED_3 : NEED_2;
          hgt_acc = hgt_acc | ({24'd0, b} << (8 * hgt_idx[1:0]));
          hgt_idx = hgt_idx + 3'd1;
          if (hgt_idx >= need) scan_phase = PH_DONE;
        end
        default: ;
      endcase
    end
    if (scan_pos < WIN_LIMIT) scan_pos++;
    if (l) begin
      res.found  = (scan_phase == PH_DONE);
      res.height = res.found ? hgt_acc : 32'd0;
      due_results.push_back(res);
      clear_parse();
    end
  endtask

  // call at a rising edge; returns at the edge that accepts the word
  task automatic send_byte(input logic [7:0] b, input logic l);
    int gap;
    gap = 0;
    while ($urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    data_byte <= b;
    last_byte <= l;
    do @(posedge clk); while (!in_ready);
    predict_byte(b, l);
    bytes_sent++;
  endtask

  task automatic send_coinbase();
    foreach (cb_bytes[i]) send_byte(cb_bytes[i], i == cb_bytes.size() - 1);
    cb_bytes.delete();
    coinbases_sent++;
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (OUT_LATENCY) @(posedge clk);
  endtask

  function automatic logic [7:0] plain_byte();
    return 8'($urandom_range(0, 254));
  endfunction

  function automatic logic [7:0] any_byte();
    case ($urandom_range(0, 7))
      0:       return FF_BYTE;
      1:       return 8'h00;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic add_plain(input int n);
    repeat (n) cb_bytes.push_back(plain_byte());
  endtask

  task automatic add_any(input int n);
    repeat (n) cb_bytes.push_back(any_byte());
  endtask

  task automatic add_ff(input int n);
    repeat (n) cb_bytes.push_back(FF_BYTE);
  endtask

  task automatic test_short_data();
    cb_bytes.push_back(FF_BYTE);
    send_coinbase();
    add_ff(HDR_BYTES);
    send_coinbase();
    add_any(HDR_BYTES);
    cb_bytes.push_back(8'h00);
    send_coinbase();
  endtask

  task automatic test_no_run();
    add_ff(HDR_BYTES);
    add_plain(WIN_BYTES + 8);
    send_coinbase();
  endtask

  task automatic test_single_ff();
    // a lone 0xff kills the parse even with a good run after it
    add_any(HDR_BYTES);
    add_plain(3);
    cb_bytes.push_back(FF_BYTE);
    cb_bytes.push_back(8'h00);
    add_ff(2);
    cb_bytes.push_back(8'h01);
    cb_bytes.push_back(8'h02);
    cb_bytes.push_back(8'h34);
    cb_bytes.push_back(8'h12);
    add_any(4);
    send_coinbase();
    add_any(HDR_BYTES);
    cb_bytes.push_back(FF_BYTE);
    cb_bytes.push_back(8'h00);
    send_coinbase();
  endtask

  task automatic test_window_edge();
    // run fills the last two window bytes
    add_any(HDR_BYTES);
    add_plain(WIN_BYTES - 2);
    add_ff(2);
    add_any(20);
    send_coinbase();
    // run reaches the end of the data
    add_any(HDR_BYTES);
    add_ff(3);
    send_coinbase();
    // two-byte field ends on the last window byte; last flag lands outside
    add_any(HDR_BYTES);
    add_plain(WIN_BYTES - 6);
    add_ff(2);
    cb_bytes.push_back(plain_byte());
    cb_bytes.push_back(8'd2);
    cb_bytes.push_back(8'hcd);
    cb_bytes.push_back(8'hab);
    add_any(30);
    send_coinbase();
    // four-byte field cut by the window end
    add_any(HDR_BYTES);
    add_plain(WIN_BYTES - 6);
    add_ff(2);
    cb_bytes.push_back(plain_byte());
    cb_bytes.push_back(HLEN_4);
    add_any(6);
    send_coinbase();
    // three-byte field cut by the end of the data
    add_any(HDR_BYTES);
    add_ff(2);
    cb_bytes.push_back(8'h00);
    cb_bytes.push_back(HLEN_3);
    cb_bytes.push_back(8'haa);
    cb_bytes.push_back(8'hbb);
    send_coinbase();
  endtask

  task automatic test_height_lengths();
    logic [7:0] lens[7];
    lens = '{8'd0, 8'd1, 8'd2, HLEN_3, HLEN_4, 8'd5, 8'hff};
    foreach (lens[i]) begin
      add_any(HDR_BYTES);
      add_plain($urandom_range(0, 4));
      add_ff(2 + $urandom_range(0, 2));
      cb_bytes.push_back(plain_byte());
      cb_bytes.push_back(lens[i]);
      add_any(4);
      add_any(3);
      send_coinbase();
    end
    // all-ones and zero heights
    add_any(HDR_BYTES);
    add_ff(2);
    cb_bytes.push_back(8'h00);
    cb_bytes.push_back(HLEN_4);
    add_ff(4);
    add_any(2);
    send_coinbase();
    add_any(HDR_BYTES);
    add_ff(2);
    cb_bytes.push_back(8'h01);
    cb_bytes.push_back(HLEN_3);
    repeat (3) cb_bytes.push_back(8'h00);
    add_ff(2);
    send_coinbase();
  endtask

  task automatic build_random_coinbase();
    int         kind;
    int         sel;
    int         cut;
    logic [7:0] hl;
    kind = $urandom_range(0, 99);
    if (kind < 15) begin
      add_any($urandom_range(1, 60));
    end else begin
      add_any(HDR_BYTES);
      add_plain(($urandom_range(0, 9) == 0) ? $urandom_range(0, WIN_BYTES)
                                            : $urandom_range(0, 6));
      if (kind < 25) begin
        cb_bytes.push_back(FF_BYTE);
        cb_bytes.push_back(plain_byte());
      end
      add_ff($urandom_range(2, 5));
      cb_bytes.push_back(plain_byte());
      sel = $urandom_range(0, 9);
      if (sel < 3) hl = HLEN_3;
      else if (sel < 6) hl = HLEN_4;
      else if (sel < 8) hl = 8'($urandom_range(0, 5));
      else hl = 8'($urandom_range(0, 255));
      cb_bytes.push_back(hl);
      add_any(4);
      add_any($urandom_range(0, 8));
      // drop the tail to truncate the sequence
      if (kind >= 25 && kind < 35) begin
        cut = $urandom_range(1, cb_bytes.size());
        while (cb_bytes.size() > cut) void'(cb_bytes.pop_back());
      end
    end
  endtask

  task automatic test_random(input idle_mode_t mode);
    int start_bytes;
    int count;
    send_idle_pct  = (mode == IDLE_SEND) ? 73 : (mode == IDLE_BOTH) ? 12 : 0;
    recv_stall_pct = (mode == IDLE_RECV) ? 73 : (mode == IDLE_BOTH) ? 12 : 0;
    start_bytes    = bytes_sent;
    count          = 0;
    while (bytes_sent - start_bytes < phase_bytes) begin
      build_random_coinbase();
      send_coinbase();
      count++;
      // hold off the sender until the pipe is empty
      if (mode == IDLE_SEND && (count == 1 || $urandom_range(0, 9) == 0))
        wait_for_results();
    end
  endtask

  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (found) found_seen++;
      if (due_results.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("unexpected result word: height %h found %b", height, found);
      end else begin
        head_result = due_results.pop_front();
        if (height !== head_result.height || found !== head_result.found) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("mismatch: expected height %h found %b, got height %h found %b",
                     head_result.height, head_result.found, height, found);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("watchdog: no word moved for %0d cycles", idle_cycles);
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    clear_parse();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_short_data();
    test_no_run();
    test_single_ff();
    test_window_edge();
    test_height_lengths();
    // split what is left of the byte budget over the four random phases
    phase_bytes = (TOTAL_BYTES - bytes_sent) / 4;
    test_random(IDLE_NONE);
    test_random(IDLE_SEND);
    test_random(IDLE_RECV);
    test_random(IDLE_BOTH);
    in_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (OUT_LATENCY + 4) @(posedge clk);
    $display("Streamed %0d coinbases, %0d bytes (%0d inside the scan window).",
             coinbases_sent, bytes_sent, window_bytes);
    $display("Checked %0d height words, %0d with found set, under four idling patterns.",
             results_seen, found_seen);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches", errors);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
